### rtl/core/sem_pkg.sv
// ----------------------------------------------------------------------------
// Session energy meter package
// Shared types and constants for the front classifier, the item queue and
// the execution back end.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int TS_W     = 32;
    localparam int CUR_W    = 18;
    localparam int VOLT_W   = 16;
    localparam int IDLE_W   = 17;
    localparam int ENERGY_W = 63;
    localparam int POWER_W  = 33;
    localparam int DUR_W    = 23;
    localparam int COUNT_W  = 32;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    // floor(x / 1000) == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x.
    localparam int               DIV_MAGIC_W = 29;
    localparam logic [28:0]      DIV_MAGIC   = 29'd274877907;
    localparam int               DIV_SHIFT   = 38;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_END    = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_UPD
    } t_state;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        t_cmd              cmd;
        logic [TS_W-1:0]   now;
        logic [CUR_W-1:0]  mag;
        logic [VOLT_W-1:0] bus_v;
        logic [IDLE_W-1:0] idle;
        logic              ok;
    } t_item;

endpackage

### rtl/core/sem_front.sv
// ----------------------------------------------------------------------------
// Session energy meter front classifier
// Decodes the command and reduces the raw currents to a sample magnitude
// and a clamped idle current before the item enters the queue.
// ----------------------------------------------------------------------------
module sem_front
    import sem_pkg::*;
(
    input  logic [1:0]         i_command,
    input  logic [TS_W-1:0]    i_timestamp_ms,
    input  logic signed [17:0] i_current_ma,
    input  logic [VOLT_W-1:0]  i_bus_voltage_mv,
    input  logic signed [17:0] i_idle_current_ma,
    input  logic               i_success,
    output t_item              o_item
);

    logic [CUR_W-1:0] mag;

    // The most negative code has magnitude 2^17, which still fits in 18 bits.
    assign mag = i_current_ma[CUR_W-1] ? (~i_current_ma + 18'd1) : i_current_ma;

    always_comb begin
        o_item.cmd   = t_cmd'(i_command);
        o_item.now   = i_timestamp_ms;
        o_item.mag   = mag;
        o_item.bus_v = i_bus_voltage_mv;
        o_item.idle  = i_idle_current_ma[CUR_W-1] ? '0 : i_idle_current_ma[IDLE_W-1:0];
        o_item.ok    = i_success;
    end

endmodule

### rtl/core/sem_queue.sv
// ----------------------------------------------------------------------------
// Session energy meter item queue
// Two-entry queue that decouples input transfers from the back end.
// ----------------------------------------------------------------------------
module sem_queue
    import sem_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_head,
    output logic  o_head_valid,
    output logic  o_full
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full       = (r_count == 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/sem_back.sv
// ----------------------------------------------------------------------------
// Session energy meter back end
// Executes one queued item at a time: power multiply, energy and
// duration multiplies, saturation, then the state update with the result.
// ----------------------------------------------------------------------------
module sem_back
    import sem_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_item               i_head,
    input  logic                i_head_valid,
    output logic                o_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output logic                o_active,
    output logic [ENERGY_W-1:0] o_session_energy,
    output logic [POWER_W-1:0]  o_peak_power,
    output logic [CUR_W-1:0]    o_peak_current,
    output logic [DUR_W-1:0]    o_duration_sec,
    output logic [ENERGY_W-1:0] o_total_energy,
    output logic [COUNT_W-1:0]  o_total_sessions,
    output logic [COUNT_W-1:0]  o_total_sessions_ok,
    output logic                o_last_valid
);

    t_state r_state;
    t_state n_state;
    logic   commit;
    logic   out_free;

    // Item in flight and its intermediate products.
    t_item                r_item;
    logic [POWER_W-1:0]   r_pwr;
    logic [TS_W-1:0]      r_dt;
    logic [TS_W-1:0]      r_span;
    logic [2*TS_W-1:0]    r_prod;
    logic [DUR_W-1:0]     r_quot;
    logic [ENERGY_W-1:0]  r_de;

    // Architectural state.
    logic                 r_running;
    logic [TS_W-1:0]      r_start_time;
    logic [TS_W-1:0]      r_last_time;
    logic [VOLT_W-1:0]    r_bus_v;
    logic [IDLE_W-1:0]    r_idle;
    logic [ENERGY_W-1:0]  r_energy;
    logic [POWER_W-1:0]   r_pk_pwr;
    logic [CUR_W-1:0]     r_pk_cur;
    logic [ENERGY_W-1:0]  r_total;
    logic [COUNT_W-1:0]   r_sess;
    logic [COUNT_W-1:0]   r_ok;
    logic [DUR_W-1:0]     r_dur;
    logic                 r_have_last;
    logic                 r_out_valid;

    logic [CUR_W-1:0]                  net;
    logic [VOLT_W+CUR_W-1:0]           pwr_full;
    logic [TS_W+DIV_MAGIC_W-1:0]       quot_full;
    logic [ENERGY_W+1:0]               de_full;
    logic                              is_sample;
    logic [ENERGY_W-1:0]               add_a;
    logic [ENERGY_W-1:0]               add_b;
    logic [ENERGY_W:0]                 add_sum;
    logic [ENERGY_W-1:0]               add_sat;
    logic                              cur_gt;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        commit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop   = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_ACC;
            ST_ACC: n_state = ST_UPD;
            ST_UPD: begin
                if (out_free) begin
                    commit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Net current over idle, floored at zero, then power in microwatts.
    assign net       = (i_head.mag > {1'b0, r_idle}) ? (i_head.mag - {1'b0, r_idle}) : '0;
    assign pwr_full  = r_bus_v * net;
    assign quot_full = r_span * DIV_MAGIC;

    // The 33-bit power times the time step, split into a 32x32 product
    // plus the top power bit shifted up by 32.
    assign de_full = {1'b0, r_prod}
                   + ({(ENERGY_W+2){r_pwr[POWER_W-1]}} & {1'b0, r_dt, {TS_W{1'b0}}});

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    r_item <= i_head;
                    r_pwr  <= pwr_full[POWER_W-1:0];
                    r_dt   <= i_head.now - r_last_time;
                    r_span <= i_head.now - r_start_time;
                end
            end
            ST_MUL: begin
                r_prod <= r_pwr[TS_W-1:0] * r_dt;
                r_quot <= quot_full[DIV_SHIFT+DUR_W-1:DIV_SHIFT];
            end
            ST_ACC: begin
                r_de <= (de_full[ENERGY_W+1:ENERGY_W] != 2'b00) ? ENERGY_MAX
                                                                : de_full[ENERGY_W-1:0];
            end
            default: ;
        endcase
    end

    // One saturating adder serves the session energy on a sample and the
    // running total when a session closes.
    assign is_sample = (r_item.cmd == CMD_SAMPLE);
    assign add_a     = is_sample ? r_energy : r_total;
    assign add_b     = is_sample ? r_de : r_energy;
    assign add_sum   = {1'b0, add_a} + {1'b0, add_b};
    assign add_sat   = add_sum[ENERGY_W] ? ENERGY_MAX : add_sum[ENERGY_W-1:0];
    assign cur_gt    = (r_item.mag > r_pk_cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_start_time <= '0;
            r_last_time  <= '0;
            r_bus_v      <= '0;
            r_idle       <= '0;
            r_energy     <= '0;
            r_pk_pwr     <= '0;
            r_pk_cur     <= '0;
            r_total      <= '0;
            r_sess       <= '0;
            r_ok         <= '0;
            r_dur        <= '0;
            r_have_last  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (commit) begin
                case (r_item.cmd)
                    CMD_START: begin
                        // A running session is closed as failed first.
                        if (r_running) begin
                            r_dur       <= r_quot;
                            r_sess      <= r_sess + 1'b1;
                            r_total     <= add_sat;
                            r_have_last <= 1'b1;
                        end
                        r_running    <= 1'b1;
                        r_start_time <= r_item.now;
                        r_last_time  <= '0;
                        r_bus_v      <= r_item.bus_v;
                        r_idle       <= r_item.idle;
                        r_energy     <= '0;
                        r_pk_pwr     <= '0;
                        r_pk_cur     <= '0;
                    end
                    CMD_SAMPLE: begin
                        if (r_running) begin
                            if (r_last_time == '0) begin
                                r_last_time <= r_item.now;
                                if (cur_gt) begin
                                    r_pk_cur <= r_item.mag;
                                end
                            end else if (r_dt == '0) begin
                                if (cur_gt) begin
                                    r_pk_cur <= r_item.mag;
                                end
                            end else begin
                                r_last_time <= r_item.now;
                                if (r_pwr != '0) begin
                                    r_energy <= add_sat;
                                    if (cur_gt) begin
                                        r_pk_cur <= r_item.mag;
                                    end
                                    if (r_pwr > r_pk_pwr) begin
                                        r_pk_pwr <= r_pwr;
                                    end
                                end
                            end
                        end
                    end
                    CMD_END: begin
                        if (r_running) begin
                            r_running   <= 1'b0;
                            r_dur       <= r_quot;
                            r_sess      <= r_sess + 1'b1;
                            if (r_item.ok) begin
                                r_ok <= r_ok + 1'b1;
                            end
                            r_total     <= add_sat;
                            r_have_last <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_active            = r_running;
    assign o_session_energy    = r_energy;
    assign o_peak_power        = r_pk_pwr;
    assign o_peak_current      = r_pk_cur;
    assign o_duration_sec      = r_dur;
    assign o_total_energy      = r_total;
    assign o_total_sessions    = r_sess;
    assign o_total_sessions_ok = r_ok;
    assign o_last_valid        = r_have_last;

    a_totals_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_UPD) |=> ($stable(r_total) && $stable(r_sess) && $stable(r_energy)))
        else $error("session state changed outside the update step");

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && r_out_valid && i_stall) |=> (r_state == ST_UPD && o_valid))
        else $error("update step did not wait for a stalled result");

    a_count_needs_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sess != $past(r_sess)) |-> ($past(r_running) && r_have_last))
        else $error("session counted without a running session");

    a_ok_with_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ok != $past(r_ok)) |-> (r_sess != $past(r_sess)))
        else $error("success counted without a session count");

endmodule

### rtl/core/session_energy_meter_core.sv
// ----------------------------------------------------------------------------
// Session energy meter core
// Integrates energy over timestamped current samples within a session.
//
// The input channel takes start, sample and end commands with i_valid and
// o_stall; each accepted command yields exactly one result on o_valid and
// i_stall, reporting the meter state after that command.
// Accepted items go into a two-entry queue. The back end takes one item at
// a time and steps through power multiply, energy and duration multiplies,
// energy saturation, then the state update; it takes no new item until the
// last has passed its update step.
// When the receiver stalls, the result holds, the back end waits in its
// update step, and the queue keeps taking items until both entries fill.
// Reset clears all session state, totals and counters and empties the queue.
// ----------------------------------------------------------------------------
module session_energy_meter_core
    import sem_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_command,
    input  logic [TS_W-1:0]     i_timestamp_ms,
    input  logic signed [17:0]  i_current_ma,
    input  logic [VOLT_W-1:0]   i_bus_voltage_mv,
    input  logic signed [17:0]  i_idle_current_ma,
    input  logic                i_success,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_active,
    output logic [ENERGY_W-1:0] o_session_energy,
    output logic [POWER_W-1:0]  o_peak_power,
    output logic [CUR_W-1:0]    o_peak_current,
    output logic [DUR_W-1:0]    o_duration_sec,
    output logic [ENERGY_W-1:0] o_total_energy,
    output logic [COUNT_W-1:0]  o_total_sessions,
    output logic [COUNT_W-1:0]  o_total_sessions_ok,
    output logic                o_last_valid
);

    t_item front_item;
    t_item head;
    logic  head_valid;
    logic  pop;

    sem_front u_front (
        .i_command         (i_command),
        .i_timestamp_ms    (i_timestamp_ms),
        .i_current_ma      (i_current_ma),
        .i_bus_voltage_mv  (i_bus_voltage_mv),
        .i_idle_current_ma (i_idle_current_ma),
        .i_success         (i_success),
        .o_item            (front_item)
    );

    sem_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_valid),
        .i_item       (front_item),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_full       (o_stall)
    );

    sem_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head              (head),
        .i_head_valid        (head_valid),
        .o_pop               (pop),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_active            (o_active),
        .o_session_energy    (o_session_energy),
        .o_peak_power        (o_peak_power),
        .o_peak_current      (o_peak_current),
        .o_duration_sec      (o_duration_sec),
        .o_total_energy      (o_total_energy),
        .o_total_sessions    (o_total_sessions),
        .o_total_sessions_ok (o_total_sessions_ok),
        .o_last_valid        (o_last_valid)
    );

endmodule

### tb/sv/session_energy_meter_core_tb.sv
// ----------------------------------------------------------------------------
// Session energy meter core testbench
// Sends start, sample and end commands through the input channel and
// compares every result transfer with a local model of the meter. A short
// table of directed commands comes first. Random sessions follow, under
// several patterns of sender gaps and receiver stalls. The rows that saturate
// the energy are sent last.
// ----------------------------------------------------------------------------
module session_energy_meter_core_tb;
    import sem_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WATCHDOG_CYCLES = 4000;
    localparam int          DRAIN_CYCLES    = 20;
    localparam int          ITEMS_PER_PHASE = 330;
    localparam logic [31:0] MS_PER_S        = 32'd1000;

    typedef struct {
        t_cmd              cmd;
        logic [TS_W-1:0]   ts;
        logic [CUR_W-1:0]  cur;
        logic [VOLT_W-1:0] volt;
        logic [CUR_W-1:0]  idle;
        logic              ok;
    } t_meter_cmd;

    typedef struct {
        logic                active;
        logic [ENERGY_W-1:0] session_energy;
        logic [POWER_W-1:0]  peak_power;
        logic [CUR_W-1:0]    peak_current;
        logic [DUR_W-1:0]    duration_sec;
        logic [ENERGY_W-1:0] total_energy;
        logic [COUNT_W-1:0]  total_sessions;
        logic [COUNT_W-1:0]  total_sessions_ok;
        logic                last_valid;
    } t_meter_reading;

    typedef struct {
        t_meter_cmd     item;
        logic           known;
        t_meter_reading reading;
    } t_stim_row;

    logic                       i_clk             = 1'b0;
    logic                       i_rst_n           = 1'b0;
    logic                       i_valid           = 1'b0;
    logic                       o_stall;
    logic [1:0]                 i_command         = CMD_NONE;
    logic [TS_W-1:0]            i_timestamp_ms    = '0;
    logic signed [CUR_W-1:0]    i_current_ma      = '0;
    logic [VOLT_W-1:0]          i_bus_voltage_mv  = '0;
    logic signed [CUR_W-1:0]    i_idle_current_ma = '0;
    logic                       i_success         = 1'b0;
    logic                       o_valid;
    logic                       i_stall           = 1'b0;
    logic                       o_active;
    logic [ENERGY_W-1:0]        o_session_energy;
    logic [POWER_W-1:0]         o_peak_power;
    logic [CUR_W-1:0]           o_peak_current;
    logic [DUR_W-1:0]           o_duration_sec;
    logic [ENERGY_W-1:0]        o_total_energy;
    logic [COUNT_W-1:0]         o_total_sessions;
    logic [COUNT_W-1:0]         o_total_sessions_ok;
    logic                       o_last_valid;

    // Local copy of the meter state.
    logic                m_running  = 1'b0;
    logic [TS_W-1:0]     m_start    = '0;
    logic [TS_W-1:0]     m_last     = '0;
    logic [VOLT_W-1:0]   m_volt     = '0;
    logic [IDLE_W-1:0]   m_idle     = '0;
    logic [ENERGY_W-1:0] m_acc      = '0;
    logic [POWER_W-1:0]  m_ppeak    = '0;
    logic [CUR_W-1:0]    m_cpeak    = '0;
    logic [ENERGY_W-1:0] m_total    = '0;
    logic [COUNT_W-1:0]  m_sessions = '0;
    logic [COUNT_W-1:0]  m_ok_count = '0;
    logic [DUR_W-1:0]    m_dur      = '0;
    logic                m_have     = 1'b0;

    t_meter_reading pending_readings[$];
    t_stim_row      stim_rows[$];
    t_meter_reading blank;
    int             send_idle_pct = 0;
    int             stall_pct     = 0;
    int             useful_items  = 0;
    int             fail_count    = 0;
    int             quiet_cycles  = 0;

    session_energy_meter_core u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_command           (i_command),
        .i_timestamp_ms      (i_timestamp_ms),
        .i_current_ma        (i_current_ma),
        .i_bus_voltage_mv    (i_bus_voltage_mv),
        .i_idle_current_ma   (i_idle_current_ma),
        .i_success           (i_success),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_active            (o_active),
        .o_session_energy    (o_session_energy),
        .o_peak_power        (o_peak_power),
        .o_peak_current      (o_peak_current),
        .o_duration_sec      (o_duration_sec),
        .o_total_energy      (o_total_energy),
        .o_total_sessions    (o_total_sessions),
        .o_total_sessions_ok (o_total_sessions_ok),
        .o_last_valid        (o_last_valid)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [ENERGY_W-1:0] energy_sat_add(input logic [ENERGY_W-1:0] a,
                                                           input logic [ENERGY_W-1:0] b);
        logic [ENERGY_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[ENERGY_W] ? ENERGY_MAX : sum[ENERGY_W-1:0];
    endfunction

    function automatic void close_session(input logic [TS_W-1:0] now, input logic ok);
        logic [TS_W-1:0] span;
        if (!m_running) begin
            return;
        end
        span       = now - m_start;
        m_running  = 1'b0;
        m_dur      = DUR_W'(span / MS_PER_S);
        m_sessions = m_sessions + 1'b1;
        if (ok) begin
            m_ok_count = m_ok_count + 1'b1;
        end
        m_total = energy_sat_add(m_total, m_acc);
        m_have  = 1'b1;
    endfunction

    function automatic t_meter_reading meter_predict(input t_meter_cmd it);
        logic [CUR_W-1:0]      mag;
        logic [CUR_W-1:0]      net;
        logic [POWER_W-1:0]    pwr;
        logic [TS_W-1:0]       dt;
        logic [ENERGY_W+1:0]   prod;
        logic [ENERGY_W-1:0]   de;
        t_meter_reading        r;
        case (it.cmd)
            CMD_START: begin
                close_session(it.ts, 1'b0);
                m_running = 1'b1;
                m_start   = it.ts;
                m_last    = '0;
                m_volt    = it.volt;
                m_idle    = it.idle[CUR_W-1] ? '0 : it.idle[IDLE_W-1:0];
                m_acc     = '0;
                m_ppeak   = '0;
                m_cpeak   = '0;
            end
            CMD_SAMPLE: begin
                if (m_running) begin
                    mag = it.cur[CUR_W-1] ? (~it.cur + 1'b1) : it.cur;
                    dt  = it.ts - m_last;
                    // A stored time of zero means the session has no sample yet.
                    if (m_last == '0 || dt == '0) begin
                        if (m_last == '0) begin
                            m_last = it.ts;
                        end
                        if (mag > m_cpeak) begin
                            m_cpeak = mag;
                        end
                    end else begin
                        m_last = it.ts;
                        net = (mag > {1'b0, m_idle}) ? mag - {1'b0, m_idle} : '0;
                        if (m_volt != '0 && net != '0) begin
                            pwr  = POWER_W'(m_volt) * POWER_W'(net);
                            prod = (ENERGY_W+2)'(pwr) * (ENERGY_W+2)'(dt);
                            de   = (prod > (ENERGY_W+2)'(ENERGY_MAX)) ? ENERGY_MAX
                                                                      : prod[ENERGY_W-1:0];
                            m_acc = energy_sat_add(m_acc, de);
                            if (mag > m_cpeak) begin
                                m_cpeak = mag;
                            end
                            if (pwr > m_ppeak) begin
                                m_ppeak = pwr;
                            end
                        end
                    end
                end
            end
            CMD_END: begin
                close_session(it.ts, it.ok);
            end
            default: begin
            end
        endcase
        r.active            = m_running;
        r.session_energy    = m_acc;
        r.peak_power        = m_ppeak;
        r.peak_current      = m_cpeak;
        r.duration_sec      = m_dur;
        r.total_energy      = m_total;
        r.total_sessions    = m_sessions;
        r.total_sessions_ok = m_ok_count;
        r.last_valid        = m_have;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [CUR_W-1:0] pick_current(input logic [CUR_W-1:0] idle);
        int k;
        int m;
        k = $urandom_range(99);
        m = $urandom_range(0, 8000);
        if (k < 10) begin
            // Exactly the idle current, so the net current is zero.
            return idle[CUR_W-1] ? '0 : idle;
        end
        if (k < 70) begin
            return $urandom_range(1) ? CUR_W'(-m) : CUR_W'(m);
        end
        return CUR_W'($urandom);
    endfunction

    task automatic add_row(input t_cmd cmd, input logic [TS_W-1:0] ts, input int cur,
                           input int volt, input int idle, input logic ok,
                           input logic known, input t_meter_reading want);
        t_stim_row row;
        row.item.cmd  = cmd;
        row.item.ts   = ts;
        row.item.cur  = CUR_W'(cur);
        row.item.volt = VOLT_W'(volt);
        row.item.idle = CUR_W'(idle);
        row.item.ok   = ok;
        row.known     = known;
        row.reading   = want;
        stim_rows.push_back(row);
    endtask

    // Offers one command, waits for its transfer and queues the expected result.
    task automatic drive_cmd(input t_meter_cmd it, input logic known,
                             input t_meter_reading want);
        t_meter_reading predicted;
        logic           ignored;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_command         <= it.cmd;
        i_timestamp_ms    <= it.ts;
        i_current_ma      <= it.cur;
        i_bus_voltage_mv  <= it.volt;
        i_idle_current_ma <= it.idle;
        i_success         <= it.ok;
        do @(posedge i_clk); while (o_stall);
        ignored = (it.cmd == CMD_NONE) || (!m_running && it.cmd != CMD_START);
        if (!ignored) begin
            useful_items++;
        end
        predicted = meter_predict(it);
        pending_readings.push_back(known ? want : predicted);
    endtask

    always @(posedge i_clk) begin
        t_meter_reading want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_readings.size() == 0) begin
                    $error("result transfer with no expected result pending");
                    fail_count++;
                end else begin
                    want = pending_readings.pop_front();
                    check_field("active", 64'(want.active), 64'(o_active));
                    check_field("session_energy", 64'(want.session_energy),
                                64'(o_session_energy));
                    check_field("peak_power", 64'(want.peak_power), 64'(o_peak_power));
                    check_field("peak_current", 64'(want.peak_current), 64'(o_peak_current));
                    check_field("duration_sec", 64'(want.duration_sec), 64'(o_duration_sec));
                    check_field("total_energy", 64'(want.total_energy), 64'(o_total_energy));
                    check_field("total_sessions", 64'(want.total_sessions),
                                64'(o_total_sessions));
                    check_field("total_sessions_ok", 64'(want.total_sessions_ok),
                                64'(o_total_sessions_ok));
                    check_field("last_valid", 64'(want.last_valid), 64'(o_last_valid));
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
                $display("session_energy_meter_core verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : main_seq
        t_meter_reading   r;
        t_meter_cmd       c;
        logic [TS_W-1:0]  now_ms;
        logic [CUR_W-1:0] sess_idle;
        int               phase_goal;
        int               n_samples;
        int               k;
        int               n_early;

        blank = '{default: '0};
        now_ms = $urandom;

        // Before any session every reading is zero.
        add_row(CMD_NONE,   32'h1234_5678, 0, 0, 0, 1'b0, 1'b1, blank);
        add_row(CMD_SAMPLE, 32'd500, -7, 0, 0, 1'b0, 1'b1, blank);
        add_row(CMD_END,    32'd600, 0, 0, 0, 1'b1, 1'b1, blank);
        r = blank;
        r.active = 1'b1;
        // Negative idle current is clamped to zero.
        add_row(CMD_START,  32'd1000, 0, 65535, -5, 1'b0, 1'b1, r);
        // A first sample at time zero keeps the no-sample mark, but sets the peak.
        r.peak_current = 18'd3;
        add_row(CMD_SAMPLE, 32'd0, -3, 0, 0, 1'b0, 1'b1, r);
        add_row(CMD_SAMPLE, 32'd2000, 100, 0, 0, 1'b0, 1'b0, blank);
        add_row(CMD_SAMPLE, 32'd2000, -900, 0, 0, 1'b0, 1'b0, blank);
        add_row(CMD_SAMPLE, 32'd2250, 131071, 0, 0, 1'b0, 1'b0, blank);
        add_row(CMD_END,    32'd4999, 0, 0, 0, 1'b1, 1'b0, blank);
        // Zero bus voltage: time advances, no energy, only the first sample sets the peak.
        add_row(CMD_START,  32'hFFFF_FC18, 0, 0, 131071, 1'b0, 1'b0, blank);
        add_row(CMD_SAMPLE, 32'd5, 7, 0, 0, 1'b0, 1'b0, blank);
        add_row(CMD_SAMPLE, 32'd10, -131072, 0, 0, 1'b0, 1'b0, blank);
        // A start during a session closes it as failed, across the time wrap.
        add_row(CMD_START,  32'h0000_0BB8, 0, 12000, 2000, 1'b1, 1'b0, blank);
        add_row(CMD_SAMPLE, 32'h0000_0BB9, 2000, 0, 0, 1'b0, 1'b0, blank);
        add_row(CMD_SAMPLE, 32'h0000_0C00, 2000, 0, 0, 1'b0, 1'b0, blank);
        add_row(CMD_SAMPLE, 32'h0000_0D00, -2500, 0, 0, 1'b0, 1'b0, blank);
        add_row(CMD_START,  32'h0000_0BB7, 0, 1, 0, 1'b0, 1'b0, blank);
        add_row(CMD_SAMPLE, 32'hFFFF_FFF0, 5, 0, 0, 1'b0, 1'b0, blank);
        add_row(CMD_SAMPLE, 32'h0000_0010, -131072, 0, 0, 1'b0, 1'b0, blank);
        add_row(CMD_END,    32'h0000_0020, 0, 0, 0, 1'b0, 1'b0, blank);
        n_early = stim_rows.size();
        // Saturating rows go last, since a saturated session pins the total.
        add_row(CMD_START,  32'd0, 0, 65535, -1, 1'b0, 1'b0, blank);
        add_row(CMD_SAMPLE, 32'd1, -131072, 0, 0, 1'b0, 1'b0, blank);
        add_row(CMD_SAMPLE, 32'h4000_0001, -131072, 0, 0, 1'b0, 1'b0, blank);
        add_row(CMD_SAMPLE, 32'h8000_0001, 131071, 0, 0, 1'b0, 1'b0, blank);
        add_row(CMD_SAMPLE, 32'h0000_0001, -131072, 0, 0, 1'b0, 1'b0, blank);
        add_row(CMD_END,    32'h7FFF_FFFF, 0, 0, 0, 1'b1, 1'b0, blank);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < n_early; k++) begin
            drive_cmd(stim_rows[k].item, stim_rows[k].known, stim_rows[k].reading);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 69; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 69; end
                default: begin send_idle_pct = 25; stall_pct = 25; end
            endcase
            phase_goal = useful_items + ITEMS_PER_PHASE;
            while (useful_items < phase_goal) begin
                c.cur  = CUR_W'($urandom);
                c.volt = VOLT_W'($urandom);
                c.idle = CUR_W'($urandom);
                c.ok   = $urandom_range(1);
                if ($urandom_range(99) < 15) begin
                    // Noise: any command with any field values.
                    c.cmd = t_cmd'($urandom_range(3));
                    c.ts  = $urandom_range(1) ? TS_W'($urandom)
                                              : now_ms + $urandom_range(0, 5000);
                    drive_cmd(c, 1'b0, blank);
                end else begin
                    if ($urandom_range(9) == 0) begin
                        now_ms = $urandom;
                    end
                    k = $urandom_range(99);
                    if (k < 10) begin
                        c.volt = '0;
                    end else if (k < 80) begin
                        c.volt = VOLT_W'($urandom_range(3000, 60000));
                    end
                    k = $urandom_range(99);
                    if (k < 60) begin
                        c.idle = CUR_W'($urandom_range(0, 2000));
                    end else if (k < 80) begin
                        c.idle[CUR_W-1] = 1'b1;
                    end
                    sess_idle = c.idle;
                    c.cmd = CMD_START;
                    c.ts  = now_ms;
                    drive_cmd(c, 1'b0, blank);
                    n_samples = $urandom_range(0, 12);
                    for (int s = 0; s < n_samples; s++) begin
                        k = $urandom_range(99);
                        if (k < 6) begin
                            now_ms = now_ms;
                        end else if (k < 12) begin
                            now_ms = now_ms + $urandom_range(100000, 4000000);
                        end else begin
                            now_ms = now_ms + $urandom_range(1, 2000);
                        end
                        c.cmd = CMD_SAMPLE;
                        c.ts  = now_ms;
                        c.cur = pick_current(sess_idle);
                        drive_cmd(c, 1'b0, blank);
                    end
                    // Some sessions are left open for the next start to close.
                    if ($urandom_range(9) != 0) begin
                        now_ms = now_ms + $urandom_range(0, 3000);
                        c.cmd  = CMD_END;
                        c.ts   = now_ms;
                        c.ok   = $urandom_range(1);
                        drive_cmd(c, 1'b0, blank);
                    end
                end
            end
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        for (k = n_early; k < stim_rows.size(); k++) begin
            drive_cmd(stim_rows[k].item, stim_rows[k].known, stim_rows[k].reading);
        end
        i_valid <= 1'b0;

        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("session_energy_meter_core verification clean");
        end else begin
            $display("session_energy_meter_core verification failed");
        end
        $finish;
    end

endmodule

### session_energy_meter_core.f
rtl/core/sem_pkg.sv
rtl/core/sem_front.sv
rtl/core/sem_queue.sv
rtl/core/sem_back.sv
rtl/core/session_energy_meter_core.sv
tb/sv/session_energy_meter_core_tb.sv
